/* rtl/wnfm_pkg.sv */
// Package for the wildcard number filter match block.
// Holds sizes, character codes, state types and the walk handshake structs.
// No dependencies.
package wnfm_pkg;

  localparam int MAX_LEN = 32;
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_NUMBER  = 1'b1;

  typedef enum logic [1:0] {
    TOP_LOAD,
    TOP_CHECK,
    TOP_WALK
  } wnfm_top_state_t;

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_RD0,
    WALK_RD1,
    WALK_RD2,
    WALK_RD3,
    WALK_EVAL
  } wnfm_walk_state_t;

  typedef struct packed {
    logic             go;
    logic [LEN_W-1:0] pat_len;
    logic [LEN_W-1:0] num_len;
  } wnfm_walk_req_t;

  typedef struct packed {
    logic done;
    logic matched;
  } wnfm_walk_rsp_t;

endpackage

/* rtl/wnfm_char_ram.sv */
// Character store: one write port, one registered read port.
// Depends on wnfm_pkg for depth and address width.
module wnfm_char_ram
  import wnfm_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [MAX_LEN];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/wnfm_walk.sv */
// Greedy wildcard walk sequencer: fetches pattern and number characters
// through the two store read ports and steps one shared compare unit.
// Depends on wnfm_pkg.
module wnfm_walk
  import wnfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  wnfm_walk_req_t    req,
  output logic [ADDR_W-1:0] pat_rd_addr,
  input  logic [7:0]        pat_rd_data,
  output logic [ADDR_W-1:0] num_rd_addr,
  input  logic [7:0]        num_rd_data,
  output wnfm_walk_rsp_t    rsp
);

  wnfm_walk_state_t state_r, state_nxt;

  logic [LEN_W-1:0] p_r, p_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic             in_star_r, in_star_nxt;
  logic             ok_p_r, ok_n_r;
  logic [7:0]       c_r, f1_r, f2_r, x_r, y_r, z_r;

  logic [1:0]       offset;
  logic [LEN_W:0]   p_idx, n_idx;
  logic [7:0]       p_val, n_val;
  logic             hit, adv;

  // Read offset follows the fetch step: current, next, one after.
  always_comb begin
    case (state_r)
      WALK_RD1: offset = 2'd1;
      WALK_RD2: offset = 2'd2;
      default:  offset = 2'd0;
    endcase
  end

  assign p_idx       = {1'b0, p_r} + {{(LEN_W - 1){1'b0}}, offset};
  assign n_idx       = {1'b0, n_r} + {{(LEN_W - 1){1'b0}}, offset};
  assign pat_rd_addr = p_idx[ADDR_W-1:0];
  assign num_rd_addr = n_idx[ADDR_W-1:0];

  // Reads past a string's end see the zero character.
  assign p_val = ok_p_r ? pat_rd_data : CH_NUL;
  assign n_val = ok_n_r ? num_rd_data : CH_NUL;

  assign hit = ((x_r == f1_r) || (f1_r == CH_ANY)) &&
               ((y_r == f2_r) || (f2_r == CH_ANY) || (f2_r == CH_STAR));
  assign adv = (f2_r != CH_ANY) || (z_r == CH_DOT) || (z_r == CH_NUL);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WALK_IDLE: if (req.go) state_nxt = WALK_RD0;
      WALK_RD0:  state_nxt = WALK_RD1;
      WALK_RD1:  state_nxt = WALK_RD2;
      WALK_RD2:  state_nxt = WALK_RD3;
      WALK_RD3:  state_nxt = WALK_EVAL;
      WALK_EVAL: state_nxt = rsp.done ? WALK_IDLE : WALK_RD0;
      default:   state_nxt = WALK_IDLE;
    endcase
  end

  // Step evaluation
  always_comb begin
    p_nxt       = p_r;
    n_nxt       = n_r;
    in_star_nxt = in_star_r;
    rsp.done    = 1'b0;
    rsp.matched = 1'b0;
    unique case (state_r)
      WALK_IDLE: begin
        if (req.go) begin
          p_nxt       = '0;
          n_nxt       = '0;
          in_star_nxt = 1'b0;
        end
      end
      WALK_EVAL: begin
        if (in_star_r && (x_r == CH_NUL)) begin
          // Skip ran off the number: pass only if the star closes the pattern.
          rsp.done    = 1'b1;
          rsp.matched = (f1_r == CH_NUL);
        end else if ((c_r == CH_NUL) || (x_r == CH_NUL)) begin
          rsp.done    = 1'b1;
          rsp.matched = (c_r == CH_NUL) && (x_r == CH_NUL);
        end else if (c_r == CH_STAR) begin
          if (f1_r == CH_STAR) begin
            p_nxt = p_r + LEN_W'(1);
          end else if (hit) begin
            n_nxt       = n_r + LEN_W'(1);
            p_nxt       = adv ? (p_r + LEN_W'(2)) : (p_r + LEN_W'(1));
            in_star_nxt = 1'b0;
          end else begin
            n_nxt       = n_r + LEN_W'(1);
            in_star_nxt = 1'b1;
          end
        end else if ((c_r == CH_ANY) || (c_r == x_r)) begin
          n_nxt = n_r + LEN_W'(1);
          p_nxt = p_r + LEN_W'(1);
        end else begin
          rsp.done    = 1'b1;
          rsp.matched = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= WALK_IDLE;
      in_star_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_star_r <= in_star_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    n_r    <= n_nxt;
    ok_p_r <= p_idx < {1'b0, req.pat_len};
    ok_n_r <= n_idx < {1'b0, req.num_len};
    case (state_r)
      WALK_RD1: begin
        c_r <= p_val;
        x_r <= n_val;
      end
      WALK_RD2: begin
        f1_r <= p_val;
        y_r  <= n_val;
      end
      WALK_RD3: begin
        f2_r <= p_val;
        z_r  <= n_val;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/wildcard_number_filter_match_top.sv */
// Top level of the wildcard number filter match block.
// Loads both strings into two character stores and runs the walk sequencer.
// Depends on wnfm_pkg, wnfm_char_ram and wnfm_walk.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  input    | in_mode, in_char_code                   | word taken when start & !busy
//  result   | out_matched, out_too_long               | out_valid high for one cycle
//
// Each character word is written into its store when taken; busy stays low while loading.
// The word ending the second string raises busy: the check state, then, unless the
// check settles the result, the walk, one step per compare (at most about 2*MAX_LEN+1
// steps, each through states RD0 to RD3 and EVAL), paced by the single read port of each store.
// Reset clears lengths, end flags and the sequencers; the stores are not cleared.
// The receiver cannot stall: the result shows for one cycle and busy drops with it.
module wildcard_number_filter_match_top
  import wnfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_mode,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  output logic       out_matched,
  output logic       out_too_long
);

  wnfm_top_state_t state_r, state_nxt;

  logic [LEN_W-1:0] pat_len_r, num_len_r;
  logic             pat_end_r, num_end_r;
  logic             ovf_r;
  logic             pat0_star_r;
  logic             out_valid_r, out_matched_r, out_too_long_r;

  logic             accept;
  logic             sel_end, other_end;
  logic [LEN_W-1:0] sel_len;
  logic             char_nul, sel_full;
  logic             load_char, drop_char, end_str, both_end;
  logic             pat_wr_en, num_wr_en;

  logic             emit, emit_matched, emit_too_long, clear;

  logic [ADDR_W-1:0] pat_rd_addr, num_rd_addr;
  logic [7:0]        pat_rd_data, num_rd_data;
  wnfm_walk_req_t    walk_req;
  wnfm_walk_rsp_t    walk_rsp;

  // Input word decode: pick the string the word belongs to.
  assign accept    = start && !busy;
  assign sel_end   = (in_mode == MODE_NUMBER) ? num_end_r : pat_end_r;
  assign other_end = (in_mode == MODE_NUMBER) ? pat_end_r : num_end_r;
  assign sel_len   = (in_mode == MODE_NUMBER) ? num_len_r : pat_len_r;
  assign char_nul  = (in_char_code == CH_NUL);
  assign sel_full  = (sel_len >= LEN_W'(MAX_LEN));

  // Drop words for a string that already ended.
  assign load_char = accept && !sel_end && !char_nul && !sel_full;
  assign drop_char = accept && !sel_end && !char_nul && sel_full;
  assign end_str   = accept && !sel_end && char_nul;
  assign both_end  = end_str && other_end;

  assign pat_wr_en = load_char && (in_mode == MODE_PATTERN);
  assign num_wr_en = load_char && (in_mode == MODE_NUMBER);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TOP_LOAD:  if (both_end) state_nxt = TOP_CHECK;
      TOP_CHECK: begin
        if (ovf_r || ((pat_len_r == LEN_W'(1)) && pat0_star_r)) begin
          state_nxt = TOP_LOAD;
        end else begin
          state_nxt = TOP_WALK;
        end
      end
      TOP_WALK:  if (walk_rsp.done) state_nxt = TOP_LOAD;
      default:   state_nxt = TOP_LOAD;
    endcase
  end

  // Outputs of the control: result emit, clear of the pair, walk launch.
  always_comb begin
    emit             = 1'b0;
    emit_matched     = 1'b0;
    emit_too_long    = 1'b0;
    walk_req.go      = 1'b0;
    walk_req.pat_len = pat_len_r;
    walk_req.num_len = num_len_r;
    unique case (state_r)
      TOP_CHECK: begin
        if (ovf_r) begin
          // Oversized string forces a miss.
          emit          = 1'b1;
          emit_too_long = 1'b1;
        end else if ((pat_len_r == LEN_W'(1)) && pat0_star_r) begin
          // A lone star passes any number, empty too.
          emit         = 1'b1;
          emit_matched = 1'b1;
        end else begin
          walk_req.go = 1'b1;
        end
      end
      TOP_WALK: begin
        if (walk_rsp.done) begin
          emit         = 1'b1;
          emit_matched = walk_rsp.matched;
        end
      end
      default: ;
    endcase
  end

  assign clear = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TOP_LOAD;
      pat_len_r   <= '0;
      num_len_r   <= '0;
      pat_end_r   <= 1'b0;
      num_end_r   <= 1'b0;
      ovf_r       <= 1'b0;
      pat0_star_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (clear) begin
        pat_len_r <= '0;
        num_len_r <= '0;
        pat_end_r <= 1'b0;
        num_end_r <= 1'b0;
        ovf_r     <= 1'b0;
      end else begin
        if (pat_wr_en) pat_len_r <= pat_len_r + LEN_W'(1);
        if (num_wr_en) num_len_r <= num_len_r + LEN_W'(1);
        if (drop_char) ovf_r <= 1'b1;
        if (end_str && (in_mode == MODE_PATTERN)) pat_end_r <= 1'b1;
        if (end_str && (in_mode == MODE_NUMBER))  num_end_r <= 1'b1;
      end
      // Track whether the first pattern character is a star.
      if (pat_wr_en && (pat_len_r == '0)) begin
        pat0_star_r <= (in_char_code == CH_STAR);
      end
    end
  end

  // Hold the result for its single strobe cycle.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_matched_r  <= emit_matched;
      out_too_long_r <= emit_too_long;
    end
  end

  assign busy         = (state_r != TOP_LOAD);
  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_too_long = out_too_long_r;

  wnfm_char_ram u_pat_ram (
    .clk     (clk),
    .wr_en   (pat_wr_en),
    .wr_addr (pat_len_r[ADDR_W-1:0]),
    .wr_data (in_char_code),
    .rd_addr (pat_rd_addr),
    .rd_data (pat_rd_data)
  );

  wnfm_char_ram u_num_ram (
    .clk     (clk),
    .wr_en   (num_wr_en),
    .wr_addr (num_len_r[ADDR_W-1:0]),
    .wr_data (in_char_code),
    .rd_addr (num_rd_addr),
    .rd_data (num_rd_data)
  );

  wnfm_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (walk_req),
    .pat_rd_addr (pat_rd_addr),
    .pat_rd_data (pat_rd_data),
    .num_rd_addr (num_rd_addr),
    .num_rd_data (num_rd_data),
    .rsp         (walk_rsp)
  );

endmodule

/* bench/wnfm_checker.sv */
// Checker for the wildcard number filter match block: watches the character
// channel and the result channel, predicts each match word and compares it.
// Depends on wnfm_pkg for sizes, character codes and mode codes.
module wnfm_checker
  import wnfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_mode,
  input  logic [7:0] in_char_code,
  input  logic       out_valid,
  input  logic       out_matched,
  input  logic       out_too_long,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic matched;
    logic too_long;
  } verdict_t;

  verdict_t   verdict_q[$];

  logic [7:0] pat_mem [MAX_LEN];
  logic [7:0] num_mem [MAX_LEN];
  int         pat_len  = 0;
  int         num_len  = 0;
  logic       pat_end  = 1'b0;
  logic       num_end  = 1'b0;
  logic       overflow = 1'b0;

  function automatic logic [7:0] pat_at(int i);
    return (i < pat_len && i < MAX_LEN) ? pat_mem[i] : CH_NUL;
  endfunction

  function automatic logic [7:0] num_at(int i);
    return (i < num_len && i < MAX_LEN) ? num_mem[i] : CH_NUL;
  endfunction

  // Greedy walk of the number against the pattern.
  function automatic logic filter_walk();
    int         p;
    int         n;
    logic [7:0] c;
    logic [7:0] f1;
    logic [7:0] f2;
    logic [7:0] z;
    logic       hit;
    p = 0;
    n = 0;
    if (pat_len == 1 && pat_mem[0] == CH_STAR) return 1'b1;
    while (pat_at(p) != CH_NUL && num_at(n) != CH_NUL) begin
      c = pat_at(p);
      if (c == CH_STAR) begin
        f1 = pat_at(p + 1);
        f2 = (f1 != CH_NUL) ? pat_at(p + 2) : CH_NUL;
        if (f1 == CH_STAR) begin
          p++;
          continue;
        end
        hit = 1'b0;
        while (!hit && num_at(n) != CH_NUL) begin
          if (num_at(n) == f1 || f1 == CH_ANY) begin
            if (num_at(n + 1) == f2 || f2 == CH_ANY || f2 == CH_STAR) begin
              n++;
              z = num_at(n + 1);
              // a trailing '?' consumes its pattern slot only at a dot or the end
              if (f2 != CH_ANY || z == CH_DOT || z == CH_NUL) p++;
              hit = 1'b1;
            end
          end
          if (!hit) n++;
        end
      end else if (c == CH_ANY) begin
        n++;
      end else if (c != num_at(n)) begin
        return 1'b0;
      end else begin
        n++;
      end
      p++;
    end
    return pat_at(p) == CH_NUL && num_at(n) == CH_NUL;
  endfunction

  function automatic void predict_word(logic mode, logic [7:0] ch);
    verdict_t v;
    if (mode == MODE_PATTERN) begin
      if (pat_end) return;
      if (ch != CH_NUL) begin
        if (pat_len < MAX_LEN) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          overflow = 1'b1;
        end
        return;
      end
      pat_end = 1'b1;
    end else begin
      if (num_end) return;
      if (ch != CH_NUL) begin
        if (num_len < MAX_LEN) begin
          num_mem[num_len] = ch;
          num_len++;
        end else begin
          overflow = 1'b1;
        end
        return;
      end
      num_end = 1'b1;
    end
    if (!(pat_end && num_end)) return;
    v.matched  = overflow ? 1'b0 : filter_walk();
    v.too_long = overflow;
    verdict_q.push_back(v);
    pat_len  = 0;
    num_len  = 0;
    pat_end  = 1'b0;
    num_end  = 1'b0;
    overflow = 1'b0;
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n) begin
      // compare first: a word taken at this edge cannot cause a result yet
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result matched=%0b too_long=%0b",
                   $time, out_matched, out_too_long);
          fail_count++;
        end else begin
          v = verdict_q.pop_front();
          if (out_matched !== v.matched) begin
            $display("%0t: matched mismatch: expected %0b actual %0b",
                     $time, v.matched, out_matched);
            fail_count++;
          end
          if (out_too_long !== v.too_long) begin
            $display("%0t: too_long mismatch: expected %0b actual %0b",
                     $time, v.too_long, out_too_long);
            fail_count++;
          end
        end
      end
      if (start && !busy) predict_word(in_mode, in_char_code);
      pending_count = verdict_q.size();
    end
  end

endmodule

/* bench/wildcard_number_filter_match_top_tb.sv */
// Testbench top for the wildcard number filter match block: clock, reset,
// character stimulus and the final verdict. Checking lives in wnfm_checker.
// Depends on wnfm_pkg, wnfm_checker and the block's RTL.
module wildcard_number_filter_match_top_tb
  import wnfm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] char_q_t[$];

  // ASCII '0', base for random digits
  localparam logic [7:0] CH_ZERO = 8'h30;
  // margin for the longest walk: about 2*MAX_LEN+1 steps plus the check state
  localparam int DRAIN_CYCLES = 5 * (2 * MAX_LEN + 2) + 16;
  localparam int RANDOM_WORDS = 1600;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       start        = 1'b0;
  logic       in_mode      = MODE_PATTERN;
  logic [7:0] in_char_code = CH_NUL;
  logic       busy;
  logic       out_valid;
  logic       out_matched;
  logic       out_too_long;
  int         fail_count;
  int         pending_count;
  int         word_count   = 0;

  always #2 clk = ~clk;

  wildcard_number_filter_match_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_matched  (out_matched),
    .out_too_long (out_too_long)
  );

  wnfm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_matched   (out_matched),
    .out_too_long  (out_too_long),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Present one word and hold it until the block takes it (start & !busy).
  // Busy read right after the edge is its value at that edge.
  task automatic send_word(logic mode, logic [7:0] ch);
    start        <= 1'b1;
    in_mode      <= mode;
    in_char_code <= ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    word_count++;
  endtask

  // Drop start for an idle gap of length n; scramble the payload so idle data is never used.
  task automatic idle(int n);
    for (int i = 0; i < n; i++) begin
      start        <= 1'b0;
      in_mode      <= 1'($urandom);
      in_char_code <= 8'($urandom);
      @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted result has come out.
  // The first edge lets the checker see the last word taken.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Mostly short gaps, a few long ones; none at all in a burst.
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(100, 30);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Send a string followed by its end code; used by the directed part.
  task automatic send_string(logic mode, string s);
    for (int i = 0; i < s.len(); i++) send_word(mode, s[i]);
    send_word(mode, CH_NUL);
  endtask

  // Interleave a pattern and a number at random, each closed by its end
  // code. Once one string has ended, now and then send it a stray word
  // that the block must drop.
  task automatic send_pair(char_q_t pq, char_q_t nq, bit burst);
    int pi;
    int ni;
    pi = 0;
    ni = 0;
    while (pi <= pq.size() || ni <= nq.size()) begin
      if (pi <= pq.size() && (ni > nq.size() || $urandom_range(1) == 1)) begin
        send_word(MODE_PATTERN, (pi < pq.size()) ? pq[pi] : CH_NUL);
        pi++;
      end else begin
        send_word(MODE_NUMBER, (ni < nq.size()) ? nq[ni] : CH_NUL);
        ni++;
      end
      if (pi > pq.size() && ni <= nq.size() && $urandom_range(9) == 0)
        send_word(MODE_PATTERN, 8'($urandom));
      else if (ni > nq.size() && pi <= pq.size() && $urandom_range(9) == 0)
        send_word(MODE_NUMBER, 8'($urandom));
      idle(pick_gap(burst));
    end
  endtask

  // Build a pattern, then a number that mostly fits it, with some damage.
  task automatic make_fitting_pair(output char_q_t pq, output char_q_t nq);
    int plen;
    int r;
    int idx;
    pq   = {};
    nq   = {};
    plen = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(MAX_LEN, 9);
    for (int i = 0; i < plen; i++) begin
      r = $urandom_range(99);
      if (r < 40)      pq.push_back(rand_digit());
      else if (r < 55) pq.push_back(CH_STAR);
      else if (r < 70) pq.push_back(CH_ANY);
      else if (r < 80) pq.push_back(CH_DOT);
      else             pq.push_back(8'($urandom_range(255, 1)));
    end
    foreach (pq[i]) begin
      if (pq[i] == CH_STAR) begin
        repeat ($urandom_range(3)) nq.push_back(rand_digit());
      end else if (pq[i] == CH_ANY) begin
        nq.push_back(($urandom_range(3) == 0) ? CH_DOT : rand_digit());
      end else begin
        nq.push_back(pq[i]);
      end
    end
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(2))
        0: if (nq.size() > 0) begin
          idx     = $urandom_range(nq.size() - 1);
          nq[idx] = 8'($urandom_range(255, 1));
        end
        1: nq.push_back(rand_digit());
        default: if (nq.size() > 0) void'(nq.pop_back());
      endcase
    end
    while (nq.size() > MAX_LEN) void'(nq.pop_back());
  endtask

  initial begin
    char_q_t pq;
    char_q_t nq;
    int      kind;
    int      pairs;
    bit      burst;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both empty, lone star, star then any before a dot,
    // stray word after an end, high and low bit literals, collapsed stars.
    send_string(MODE_PATTERN, "");
    send_string(MODE_NUMBER, "");
    send_string(MODE_PATTERN, "*");
    send_string(MODE_NUMBER, "4");
    send_string(MODE_NUMBER, "5.");
    send_string(MODE_PATTERN, "*?");
    send_word(MODE_PATTERN, CH_NUL);
    send_word(MODE_PATTERN, 8'hFF);
    send_word(MODE_NUMBER, 8'hFF);
    send_word(MODE_NUMBER, CH_NUL);
    send_word(MODE_PATTERN, 8'h80);
    send_word(MODE_PATTERN, CH_NUL);
    send_word(MODE_NUMBER, 8'h01);
    send_word(MODE_NUMBER, CH_NUL);
    send_string(MODE_PATTERN, "**5");
    send_string(MODE_NUMBER, "25");
    drain();

    // Random: mostly well-formed pairs, some over length, some noise.
    word_count = 0;
    pairs      = 0;
    while (word_count < RANDOM_WORDS) begin
      burst = ($urandom_range(3) == 0);
      kind  = $urandom_range(99);
      if (kind < 75) begin
        make_fitting_pair(pq, nq);
        send_pair(pq, nq, burst);
      end else if (kind < 80) begin
        // lone star against anything
        pq = {CH_STAR};
        nq = {};
        repeat ($urandom_range(10)) nq.push_back(8'($urandom_range(255, 1)));
        send_pair(pq, nq, burst);
      end else if (kind < 90) begin
        // one string runs past the store
        make_fitting_pair(pq, nq);
        if ($urandom_range(1) == 1) begin
          pq = {};
          repeat ($urandom_range(MAX_LEN + 4, MAX_LEN + 1)) pq.push_back(rand_digit());
        end else begin
          nq = {};
          repeat ($urandom_range(MAX_LEN + 4, MAX_LEN + 1)) nq.push_back(rand_digit());
        end
        send_pair(pq, nq, burst);
      end else begin
        // raw noise: any mode, any byte, end codes often
        repeat ($urandom_range(6, 1)) begin
          send_word(1'($urandom),
                    ($urandom_range(9) < 3) ? CH_NUL : 8'($urandom));
          idle(pick_gap(burst));
        end
      end
      pairs++;
      if (pairs % 40 == 0) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("wildcard_number_filter_match_top verification clean");
    end else begin
      $display("wildcard_number_filter_match_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("wildcard_number_filter_match_top verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wnfm_pkg.sv
rtl/wnfm_char_ram.sv
rtl/wnfm_walk.sv
rtl/wildcard_number_filter_match_top.sv
bench/wnfm_checker.sv
bench/wildcard_number_filter_match_top_tb.sv
